/* rtl/lav_pkg.sv */
// Shared widths, types and a helper function for the look-at view matrix block.
package lav_pkg;

    // Field format: signed fixed point, DW bits with FB fraction bits.
    localparam int DW = 32;
    localparam int FB = 16;

    // Magnitude of a component difference, and of a normalised component.
    localparam int MAG_W = 32;
    localparam int NM_W = 30;
    localparam int SQ_W = 2 * NM_W;
    localparam int SUM_W = SQ_W + 2;

    // Square root: one result bit per stage.
    localparam int ROOT_W = SUM_W / 2;
    localparam int SQ_STEPS = ROOT_W;

    // Division for the unit components: one quotient bit per stage.
    localparam int DIVD_W = NM_W + FB + 1;
    localparam int Q_W = FB + 1;
    localparam int DIV_STEPS = Q_W;

    // Unit vector components lie in [-2^FB, 2^FB].
    localparam int UNIT_W = FB + 2;
    // Right and true up components.
    localparam int ROW_W = FB + 4;
    // Translation accumulator.
    localparam int ACC_W = ROW_W + DW + 3;

    // Register stages through the normalising unit.
    localparam int NORM_LAT = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;

    localparam longint WMAX = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint WMIN = -WMAX - 1;
    localparam longint HALF = longint'(1) <<< (FB - 1);

    localparam logic [1:0] LAST_ROW = 2'd3;
    localparam logic [DW-1:0] ONE_Q = DW'(longint'(1) <<< FB);

    typedef logic [DW-1:0] word_t;
    typedef logic [2:0][DW-1:0] word3_t;
    typedef logic [2:0][MAG_W-1:0] mag3_t;
    typedef logic [2:0][UNIT_W-1:0] unit3_t;
    typedef logic [2:0][3:0][DW-1:0] rows_t;

    // Arithmetic shift by FB (floor), then saturate to the field range.
    function automatic word_t sat_word(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] s;
        s = v >>> FB;
        if (s > WMAX) begin
            sat_word = DW'(WMAX);
        end else if (s < WMIN) begin
            sat_word = DW'(WMIN);
        end else begin
            sat_word = s[DW-1:0];
        end
    endfunction

endpackage

/* rtl/lav_norm.sv */
// Pipelined normaliser: scaling, sum of squares, square root and per-lane division.
module lav_norm (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [2:0]     in_neg,
    input  lav_pkg::mag3_t in_mag,
    output logic           out_valid,
    output lav_pkg::unit3_t out_unit,
    output logic           out_ok
);
    import lav_pkg::*;

    typedef logic [2:0][NM_W-1:0] nm3_t;
    typedef logic [2:0][SQ_W-1:0] sq3_t;
    typedef logic [2:0][DIVD_W-1:0] dvr3_t;
    typedef logic [2:0][Q_W-1:0] q3_t;

    // Stage 1: largest magnitude.
    logic [MAG_W-1:0] mx_next, mx1_reg;
    mag3_t            mag1_reg;
    logic [2:0]       neg1_reg;
    logic             v1_reg;

    // Stage 2: scale amount.
    logic [5:0] blen;
    logic [1:0] rsh_next, rsh2_reg;
    logic [4:0] lsh_next, lsh2_reg;
    mag3_t      mag2_reg;
    logic [2:0] neg2_reg;
    logic       ok2_reg, v2_reg;

    // Stage 3: scaled magnitudes.
    nm3_t       nm_next, nm3_reg;
    logic [2:0] neg3_reg;
    logic       ok3_reg, v3_reg;

    // Stage 4: squares.
    sq3_t       sq4_reg;
    nm3_t       nm4_reg;
    logic [2:0] neg4_reg;
    logic       ok4_reg, v4_reg;

    // Square root stages; index 0 is the sum of squares.
    logic [SUM_W-1:0]  sq_rem_reg  [SQ_STEPS+1];
    logic [ROOT_W-1:0] sq_root_reg [SQ_STEPS+1];
    nm3_t              sq_nm_reg   [SQ_STEPS+1];
    logic [2:0]        sq_neg_reg  [SQ_STEPS+1];
    logic              sq_ok_reg   [SQ_STEPS+1];
    logic              sq_v_reg    [SQ_STEPS+1];

    // Division stages; index 0 holds the rounded dividends.
    dvr3_t             dv_rem_reg [DIV_STEPS+1];
    q3_t               dv_q_reg   [DIV_STEPS+1];
    logic [ROOT_W-1:0] dv_len_reg [DIV_STEPS+1];
    logic [2:0]        dv_neg_reg [DIV_STEPS+1];
    logic              dv_ok_reg  [DIV_STEPS+1];
    logic              dv_v_reg   [DIV_STEPS+1];

    logic [ROOT_W-1:0] len;
    dvr3_t             dvd_next;
    unit3_t            unit_next;

    always_comb begin
        mx_next = in_mag[0];
        if (in_mag[1] > mx_next) begin
            mx_next = in_mag[1];
        end
        if (in_mag[2] > mx_next) begin
            mx_next = in_mag[2];
        end
    end

    always_comb begin
        blen = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (mx1_reg[i]) begin
                blen = 6'(i + 1);
            end
        end
        if (int'(blen) > NM_W) begin
            rsh_next = 2'(int'(blen) - NM_W);
            lsh_next = '0;
        end else begin
            rsh_next = '0;
            lsh_next = 5'(NM_W - int'(blen));
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (rsh2_reg != 2'd0) begin
                nm_next[i] = NM_W'(mag2_reg[i] >> rsh2_reg);
            end else begin
                nm_next[i] = NM_W'(mag2_reg[i] << lsh2_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx1_reg  <= mx_next;
            mag1_reg <= in_mag;
            neg1_reg <= in_neg;
            mag2_reg <= mag1_reg;
            neg2_reg <= neg1_reg;
            rsh2_reg <= rsh_next;
            lsh2_reg <= lsh_next;
            ok2_reg  <= mx1_reg != '0;
            nm3_reg  <= nm_next;
            neg3_reg <= neg2_reg;
            ok3_reg  <= ok2_reg;
            for (int i = 0; i < 3; i++) begin
                sq4_reg[i] <= nm3_reg[i] * nm3_reg[i];
            end
            nm4_reg  <= nm3_reg;
            neg4_reg <= neg3_reg;
            ok4_reg  <= ok3_reg;
            sq_rem_reg[0]  <= SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) + SUM_W'(sq4_reg[2]);
            sq_root_reg[0] <= '0;
            sq_nm_reg[0]   <= nm4_reg;
            sq_neg_reg[0]  <= neg4_reg;
            sq_ok_reg[0]   <= ok4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end else if (en) begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            sq_v_reg[0] <= v4_reg;
        end
    end

    // Digit-by-digit square root, most significant root bit first.
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        localparam int K = SQ_STEPS - 1 - j;
        logic [SUM_W:0] trial;
        logic           take;

        assign trial = {(SUM_W + 1 - ROOT_W - 2)'(0), sq_root_reg[j], 2'b01} << (2 * K);
        assign take  = {1'b0, sq_rem_reg[j]} >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[j+1]  <= take ? sq_rem_reg[j] - trial[SUM_W-1:0] : sq_rem_reg[j];
                sq_root_reg[j+1] <= {sq_root_reg[j][ROOT_W-2:0], take};
                sq_nm_reg[j+1]   <= sq_nm_reg[j];
                sq_neg_reg[j+1]  <= sq_neg_reg[j];
                sq_ok_reg[j+1]   <= sq_ok_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[j+1] <= 1'b0;
            end else if (en) begin
                sq_v_reg[j+1] <= sq_v_reg[j];
            end
        end
    end

    // Dividend with half the divisor added, so the quotient rounds half up.
    assign len = sq_root_reg[SQ_STEPS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dvd_next[i] = DIVD_W'({sq_nm_reg[SQ_STEPS][i], FB'(0)}) + DIVD_W'(len >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0] <= dvd_next;
            dv_q_reg[0]   <= '0;
            dv_len_reg[0] <= len;
            dv_neg_reg[0] <= sq_neg_reg[SQ_STEPS];
            dv_ok_reg[0]  <= sq_ok_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (en) begin
            dv_v_reg[0] <= sq_v_reg[SQ_STEPS];
        end
    end

    // Restoring division, three lanes sharing one divisor.
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int B = DIV_STEPS - 1 - j;
        logic [DIVD_W-1:0] trial;
        logic [2:0]        take;

        assign trial = DIVD_W'(dv_len_reg[j]) << B;

        for (genvar i = 0; i < 3; i++) begin : g_lane
            assign take[i] = dv_rem_reg[j][i] >= trial;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    dv_rem_reg[j+1][i] <= take[i] ? dv_rem_reg[j][i] - trial : dv_rem_reg[j][i];
                    dv_q_reg[j+1][i]   <= {dv_q_reg[j][i][Q_W-2:0], take[i]};
                end
                dv_len_reg[j+1] <= dv_len_reg[j];
                dv_neg_reg[j+1] <= dv_neg_reg[j];
                dv_ok_reg[j+1]  <= dv_ok_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end
    end

    // A zero-length vector gives a zero unit vector.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!dv_ok_reg[DIV_STEPS]) begin
                unit_next[i] = '0;
            end else if (dv_neg_reg[DIV_STEPS][i]) begin
                unit_next[i] = -UNIT_W'({1'b0, dv_q_reg[DIV_STEPS][i]});
            end else begin
                unit_next[i] = UNIT_W'({1'b0, dv_q_reg[DIV_STEPS][i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_unit <= unit_next;
            out_ok   <= dv_ok_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= dv_v_reg[DIV_STEPS];
        end
    end

endmodule

/* rtl/lav_xform.sv */
// Cross products and translation column, seven register stages.
module lav_xform (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic            in_degen,
    input  lav_pkg::unit3_t in_fwd,
    input  lav_pkg::unit3_t in_up,
    input  lav_pkg::word3_t in_eye,
    output logic            out_valid,
    output lav_pkg::rows_t  out_rows,
    output logic            out_degen
);
    import lav_pkg::*;

    localparam int P1_W = 2 * UNIT_W;
    localparam int P3_W = ROW_W + UNIT_W;
    localparam int PT_W = ROW_W + DW;

    typedef logic [2:0][ROW_W-1:0] row3_t;
    typedef logic [2:0][PT_W-1:0] pt3_t;
    typedef logic [2:0][ACC_W-1:0] acc3_t;

    logic signed [P1_W-1:0] c1a_next [3], c1b_next [3], c1a_reg [3], c1b_reg [3];
    logic signed [P1_W:0]   d1 [3];
    row3_t                  right_next, right2_reg, right3_reg;
    logic signed [P3_W-1:0] c3a_next [3], c3b_next [3], c3a_reg [3], c3b_reg [3];
    logic signed [P3_W:0]   d3 [3];
    row3_t                  up_next, nf_next;
    row3_t                  row4_reg [3];
    pt3_t                   pt_next [3], pt5_reg [3];
    row3_t                  row5_reg [3], row6_reg [3];
    acc3_t                  acc_next, acc6_reg;
    rows_t                  rows_next;

    unit3_t fwd1_reg, fwd2_reg, fwd3_reg;
    word3_t eye1_reg, eye2_reg, eye3_reg, eye4_reg;
    logic [6:1] dg_reg, v_reg;

    // Forward crossed with the normalised up hint.
    always_comb begin
        c1a_next[0] = $signed(in_fwd[1]) * $signed(in_up[2]);
        c1b_next[0] = $signed(in_fwd[2]) * $signed(in_up[1]);
        c1a_next[1] = $signed(in_fwd[2]) * $signed(in_up[0]);
        c1b_next[1] = $signed(in_fwd[0]) * $signed(in_up[2]);
        c1a_next[2] = $signed(in_fwd[0]) * $signed(in_up[1]);
        c1b_next[2] = $signed(in_fwd[1]) * $signed(in_up[0]);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d1[i] = (P1_W + 1)'(c1a_reg[i]) - (P1_W + 1)'(c1b_reg[i]) + (P1_W + 1)'(HALF);
            right_next[i] = ROW_W'(d1[i] >>> FB);
        end
    end

    // Right crossed with forward gives the true up.
    always_comb begin
        c3a_next[0] = $signed(right2_reg[1]) * $signed(fwd2_reg[2]);
        c3b_next[0] = $signed(right2_reg[2]) * $signed(fwd2_reg[1]);
        c3a_next[1] = $signed(right2_reg[2]) * $signed(fwd2_reg[0]);
        c3b_next[1] = $signed(right2_reg[0]) * $signed(fwd2_reg[2]);
        c3a_next[2] = $signed(right2_reg[0]) * $signed(fwd2_reg[1]);
        c3b_next[2] = $signed(right2_reg[1]) * $signed(fwd2_reg[0]);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d3[i] = (P3_W + 1)'(c3a_reg[i]) - (P3_W + 1)'(c3b_reg[i]) + (P3_W + 1)'(HALF);
            up_next[i] = ROW_W'(d3[i] >>> FB);
            nf_next[i] = -ROW_W'($signed(fwd3_reg[i]));
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                pt_next[k][i] = PT_W'($signed(row4_reg[k][i])) * PT_W'($signed(eye4_reg[i]));
            end
        end
    end

    // Negated dot product with the eye, plus half for round half up.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc_next[k] = -(ACC_W'($signed(pt5_reg[k][0])) + ACC_W'($signed(pt5_reg[k][1]))
                            + ACC_W'($signed(pt5_reg[k][2]))) + ACC_W'(HALF);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                rows_next[k][i] = DW'($signed(row6_reg[k][i]));
            end
            rows_next[k][3] = sat_word(acc6_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1a_reg    <= c1a_next;
            c1b_reg    <= c1b_next;
            fwd1_reg   <= in_fwd;
            eye1_reg   <= in_eye;
            right2_reg <= right_next;
            fwd2_reg   <= fwd1_reg;
            eye2_reg   <= eye1_reg;
            c3a_reg    <= c3a_next;
            c3b_reg    <= c3b_next;
            right3_reg <= right2_reg;
            fwd3_reg   <= fwd2_reg;
            eye3_reg   <= eye2_reg;
            row4_reg[0] <= right3_reg;
            row4_reg[1] <= up_next;
            row4_reg[2] <= nf_next;
            eye4_reg   <= eye3_reg;
            pt5_reg    <= pt_next;
            row5_reg   <= row4_reg;
            acc6_reg   <= acc_next;
            row6_reg   <= row5_reg;
            out_rows   <= rows_next;
            dg_reg     <= {dg_reg[5:1], in_degen};
            out_degen  <= dg_reg[6];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= '0;
            out_valid <= 1'b0;
        end else if (en) begin
            v_reg     <= {v_reg[5:1], in_valid};
            out_valid <= v_reg[6];
        end
    end

endmodule

/* rtl/lav_rowser.sv */
// Output register that sends a finished matrix one row per transaction.
module lav_rowser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  lav_pkg::rows_t       in_rows,
    input  logic                 in_degen,
    output logic                 en,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_row_index,
    output logic [lav_pkg::DW-1:0] m_col0,
    output logic [lav_pkg::DW-1:0] m_col1,
    output logic [lav_pkg::DW-1:0] m_col2,
    output logic [lav_pkg::DW-1:0] m_col3,
    output logic                 m_last_row,
    output logic                 m_degenerate
);
    import lav_pkg::*;

    typedef logic [3:0][3:0][DW-1:0] mat_t;

    logic       hold_reg;
    logic [1:0] row_reg;
    mat_t       mat_reg;
    logic       degen_reg;

    // The pipeline moves when no matrix is held or its last row leaves now.
    assign en = !hold_reg || (m_ready && row_reg == LAST_ROW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
            row_reg  <= '0;
        end else if (en) begin
            hold_reg <= in_valid;
            row_reg  <= '0;
        end else if (m_ready) begin
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mat_reg[2:0] <= in_rows;
            mat_reg[3]   <= {ONE_Q, {(3 * DW){1'b0}}};
            degen_reg    <= in_degen;
        end
    end

    assign m_valid      = hold_reg;
    assign m_row_index  = row_reg;
    assign m_col0       = mat_reg[row_reg][0];
    assign m_col1       = mat_reg[row_reg][1];
    assign m_col2       = mat_reg[row_reg][2];
    assign m_col3       = mat_reg[row_reg][3];
    assign m_last_row   = row_reg == LAST_ROW;
    assign m_degenerate = degen_reg;

endmodule

/* rtl/look_at_view_matrix.sv */
// Top level of the fixed-point look-at view matrix block.
//
//   channel | direction | handshake          | transaction carries
//   --------+-----------+--------------------+----------------------------------------
//   s_      | in        | s_valid / s_ready  | eye, target and up hint, Q16.16
//   m_      | out       | m_valid / m_ready  | one matrix row, its index and flags
//
// Every input transaction yields four output transactions, rows 0 to 3 in order.
// The pipeline holds one stage of input differences, the normaliser (scaling,
// sum of squares, 31 square-root stages and 17 division stages, 55 stages in all)
// and seven stages of cross products and translation. The row serialiser sends
// four rows per matrix, so a new transaction is accepted only while no matrix
// is held or as the last row of the held matrix leaves.
// The whole pipeline advances together; while the serialiser still has rows to
// send, s_ready is low and every stage holds. Reset (aresetn low, synchronous)
// clears only the valid bits and the row counter.
module look_at_view_matrix (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [lav_pkg::DW-1:0] s_eye_x,
    input  logic signed [lav_pkg::DW-1:0] s_eye_y,
    input  logic signed [lav_pkg::DW-1:0] s_eye_z,
    input  logic signed [lav_pkg::DW-1:0] s_target_x,
    input  logic signed [lav_pkg::DW-1:0] s_target_y,
    input  logic signed [lav_pkg::DW-1:0] s_target_z,
    input  logic signed [lav_pkg::DW-1:0] s_up_x,
    input  logic signed [lav_pkg::DW-1:0] s_up_y,
    input  logic signed [lav_pkg::DW-1:0] s_up_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_row_index,
    output logic signed [lav_pkg::DW-1:0] m_col0,
    output logic signed [lav_pkg::DW-1:0] m_col1,
    output logic signed [lav_pkg::DW-1:0] m_col2,
    output logic signed [lav_pkg::DW-1:0] m_col3,
    output logic                          m_last_row,
    output logic                          m_degenerate
);
    import lav_pkg::*;

    logic en;

    word3_t eye_in, tgt_in, up_in;
    logic signed [DW:0] fd [3];
    logic [2:0] fneg_next, uneg_next;
    mag3_t      fmag_next, umag_next;

    logic [2:0] fneg_reg, uneg_reg;
    mag3_t      fmag_reg, umag_reg;
    word3_t     eye_reg;
    logic       va_reg;

    word3_t eye_dly_reg [NORM_LAT];

    logic   nf_valid, nu_valid, nf_ok, nu_ok;
    unit3_t fwd_unit, up_unit;

    logic  xf_valid, xf_degen;
    rows_t xf_rows;

    assign s_ready = en;

    assign eye_in = {s_eye_z, s_eye_y, s_eye_x};
    assign tgt_in = {s_target_z, s_target_y, s_target_x};
    assign up_in  = {s_up_z, s_up_y, s_up_x};

    // Target minus eye is formed exactly, then split into sign and magnitude.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fd[i] = (DW + 1)'($signed(tgt_in[i])) - (DW + 1)'($signed(eye_in[i]));
            fneg_next[i] = fd[i][DW];
            fmag_next[i] = fd[i][DW] ? MAG_W'(-fd[i]) : MAG_W'(fd[i]);
            uneg_next[i] = up_in[i][DW-1];
            umag_next[i] = up_in[i][DW-1] ? MAG_W'(-up_in[i]) : MAG_W'(up_in[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fneg_reg <= fneg_next;
            fmag_reg <= fmag_next;
            uneg_reg <= uneg_next;
            umag_reg <= umag_next;
            eye_reg  <= eye_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_valid;
        end
    end

    // The eye travels beside the normaliser so that it meets its own vectors.
    always_ff @(posedge aclk) begin
        if (en) begin
            eye_dly_reg[0] <= eye_reg;
            for (int i = 1; i < NORM_LAT; i++) begin
                eye_dly_reg[i] <= eye_dly_reg[i-1];
            end
        end
    end

    lav_norm u_norm_fwd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (va_reg),
        .in_neg    (fneg_reg),
        .in_mag    (fmag_reg),
        .out_valid (nf_valid),
        .out_unit  (fwd_unit),
        .out_ok    (nf_ok)
    );

    lav_norm u_norm_up (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (va_reg),
        .in_neg    (uneg_reg),
        .in_mag    (umag_reg),
        .out_valid (nu_valid),
        .out_unit  (up_unit),
        .out_ok    (nu_ok)
    );

    lav_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (nf_valid && nu_valid),
        .in_degen  (!nf_ok || !nu_ok),
        .in_fwd    (fwd_unit),
        .in_up     (up_unit),
        .in_eye    (eye_dly_reg[NORM_LAT-1]),
        .out_valid (xf_valid),
        .out_rows  (xf_rows),
        .out_degen (xf_degen)
    );

    lav_rowser u_rowser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (xf_valid),
        .in_rows      (xf_rows),
        .in_degen     (xf_degen),
        .en           (en),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_row_index  (m_row_index),
        .m_col0       (m_col0),
        .m_col1       (m_col1),
        .m_col2       (m_col2),
        .m_col3       (m_col3),
        .m_last_row   (m_last_row),
        .m_degenerate (m_degenerate)
    );

`ifndef SYNTHESIS
    // A row that is taken before the last one is followed by the next row.
    a_row_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_row
        |=> m_valid && m_row_index == $past(m_row_index) + 2'd1)
        else $error("row index did not advance after a taken row");

    // No new input is taken while a matrix still has rows to send.
    a_no_accept_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_row |-> !s_ready)
        else $error("input accepted while a matrix was part sent");

    // The degenerate flag is the same on every row of one matrix.
    a_degen_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_row |=> $stable(m_degenerate))
        else $error("degenerate flag changed within a matrix");

    // The fourth row is always 0, 0, 0, 1.
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_row |-> m_col0 == '0 && m_col1 == '0 && m_col2 == '0
                                  && m_col3 == ONE_Q)
        else $error("fourth row is not 0, 0, 0, 1");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the look-at view matrix block, with its own row predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lav_pkg::*;

    // The watchdog limit allows for the pipeline latency, for the long receiver
    // hold-off and for the longest sender gap, several times over.
    localparam int PIPE_LAT = 63;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS = 45;
    localparam int PRESSURE_ITEMS = 70;

    // Codes for the stimulus shapes used by the random part.
    typedef enum int {
        SHAPE_SCENE, SHAPE_BITS, SHAPE_SAME_POINT, SHAPE_ZERO_UP, SHAPE_EDGE
    } shape_e;

    typedef longint vec3_t [3];

    // One camera description, as it is sent on the input channel.
    typedef struct {
        logic signed [DW-1:0] eye [3];
        logic signed [DW-1:0] target [3];
        logic signed [DW-1:0] up [3];
    } camera_t;

    // One matrix row, as it is expected on the output channel.
    typedef struct {
        logic [1:0]    idx;
        logic [DW-1:0] c0, c1, c2, c3;
        logic          last;
        logic          degen;
    } row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [DW-1:0] s_eye_x, s_eye_y, s_eye_z;
    logic signed [DW-1:0] s_target_x, s_target_y, s_target_z;
    logic signed [DW-1:0] s_up_x, s_up_y, s_up_z;
    logic m_valid;
    logic m_ready;
    logic [1:0] m_row_index;
    logic signed [DW-1:0] m_col0, m_col1, m_col2, m_col3;
    logic m_last_row;
    logic m_degenerate;

    // Rows still owed by the block, oldest first.
    row_t pending_rows [$];

    int mismatches = 0;
    int matrices_sent = 0;
    int rows_checked = 0;
    int degenerate_sent = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int hold_request = 0;
    bit saturated_seen = 0;

    look_at_view_matrix uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_eye_x     (s_eye_x),
        .s_eye_y     (s_eye_y),
        .s_eye_z     (s_eye_z),
        .s_target_x  (s_target_x),
        .s_target_y  (s_target_y),
        .s_target_z  (s_target_z),
        .s_up_x      (s_up_x),
        .s_up_y      (s_up_y),
        .s_up_z      (s_up_z),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_row_index (m_row_index),
        .m_col0      (m_col0),
        .m_col1      (m_col1),
        .m_col2      (m_col2),
        .m_col3      (m_col3),
        .m_last_row  (m_last_row),
        .m_degenerate(m_degenerate)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Integer square root, rounded down.
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Turns a sign and magnitude vector into a unit vector in FB fraction
    // bits. The magnitudes share one power-of-two scale that puts the largest
    // in [2^29, 2^30); right shifts truncate. Returns 0 for a zero vector.
    function automatic bit unit_vector(input bit neg [3], input longint unsigned mag [3],
                                       output vec3_t unit);
        longint unsigned m [3];
        longint unsigned largest, sum, len, q;
        largest = 0;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag[i];
            if (m[i] > largest) largest = m[i];
        end
        if (largest == 0) begin
            unit = '{0, 0, 0};
            return 1'b0;
        end
        while (largest >= (64'd1 << 30)) begin
            largest >>= 1;
            for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (largest < (64'd1 << 29)) begin
            largest <<= 1;
            for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++) sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FB) + (len >> 1)) / len;
            unit[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    // Divides by 2^FB with round half up (add a half, then floor).
    function automatic longint round_frac(input longint v);
        return (v + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t r);
        r[0] = round_frac(a[1] * b[2] - a[2] * b[1]);
        r[1] = round_frac(a[2] * b[0] - a[0] * b[2]);
        r[2] = round_frac(a[0] * b[1] - a[1] * b[0]);
    endfunction

    function automatic logic [DW-1:0] clamp_word(input longint v);
        if (v > WMAX) begin
            saturated_seen = 1'b1;
            return DW'(WMAX);
        end
        if (v < WMIN) begin
            saturated_seen = 1'b1;
            return DW'(WMIN);
        end
        return DW'(v);
    endfunction

    // Builds the four rows of the view matrix for one camera and queues them.
    // Every product here stays well inside 64 bits, so plain longint is exact.
    function automatic void predict_view_rows(input camera_t cam);
        bit fneg [3], uneg [3];
        longint unsigned fmag [3], umag [3];
        longint e, t, u, dot;
        vec3_t fwd, up_unit, right, true_up, back;
        vec3_t basis [3];
        bit fwd_ok, up_ok, degen;
        row_t r;
        for (int i = 0; i < 3; i++) begin
            e = longint'(cam.eye[i]);
            t = longint'(cam.target[i]);
            u = longint'(cam.up[i]);
            fneg[i] = t < e;
            fmag[i] = fneg[i] ? longint'(e - t) : longint'(t - e);
            uneg[i] = u < 0;
            umag[i] = uneg[i] ? -u : u;
        end
        fwd_ok = unit_vector(fneg, fmag, fwd);
        up_ok = unit_vector(uneg, umag, up_unit);
        degen = !fwd_ok || !up_ok;
        cross3(fwd, up_unit, right);
        cross3(right, fwd, true_up);
        for (int i = 0; i < 3; i++) back[i] = -fwd[i];
        basis[0] = right;
        basis[1] = true_up;
        basis[2] = back;
        for (int k = 0; k < 3; k++) begin
            dot = 0;
            for (int i = 0; i < 3; i++) dot += basis[k][i] * longint'(cam.eye[i]);
            r.idx = 2'(k);
            r.c0 = clamp_word(basis[k][0]);
            r.c1 = clamp_word(basis[k][1]);
            r.c2 = clamp_word(basis[k][2]);
            r.c3 = clamp_word(round_frac(-dot));
            r.last = 1'b0;
            r.degen = degen;
            pending_rows.push_back(r);
        end
        r.idx = LAST_ROW;
        r.c0 = '0;
        r.c1 = '0;
        r.c2 = '0;
        r.c3 = ONE_Q;
        r.last = 1'b1;
        r.degen = degen;
        pending_rows.push_back(r);
        if (degen) degenerate_sent++;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one camera and returns once the transaction has been accepted.
    // Bursts of back-to-back transactions are separated by random gaps; the
    // valid line is only lowered at the start of a gap, so it is never
    // lowered and raised in the same time step.
    task automatic send_camera(input camera_t cam);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_eye_x    <= cam.eye[0];
        s_eye_y    <= cam.eye[1];
        s_eye_z    <= cam.eye[2];
        s_target_x <= cam.target[0];
        s_target_y <= cam.target[1];
        s_target_z <= cam.target[2];
        s_up_x     <= cam.up[0];
        s_up_y     <= cam.up[1];
        s_up_z     <= cam.up[2];
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        predict_view_rows(cam);
        matrices_sent++;
    endtask

    // Lets the pipeline run dry: every owed row must arrive first.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_rows.size() != 0) @(posedge aclk);
    endtask

    function automatic camera_t make_camera(input longint ex, ey, ez, tx, ty, tz,
                                            ux, uy, uz);
        camera_t c;
        c.eye = '{DW'(ex), DW'(ey), DW'(ez)};
        c.target = '{DW'(tx), DW'(ty), DW'(tz)};
        c.up = '{DW'(ux), DW'(uy), DW'(uz)};
        return c;
    endfunction

    function automatic logic [DW-1:0] scene_coord();
        return DW'(longint'($urandom_range(0, 1 << 24)) - (1 << 23));
    endfunction

    // Random camera of a given shape. Most shapes are sensible scenes with
    // random content; the bit shape drives every field bit both ways.
    function automatic camera_t random_camera(input shape_e shape);
        camera_t c;
        for (int i = 0; i < 3; i++) begin
            c.eye[i] = scene_coord();
            c.target[i] = scene_coord();
            c.up[i] = scene_coord();
        end
        case (shape)
            SHAPE_BITS: begin
                for (int i = 0; i < 3; i++) begin
                    c.eye[i] = $urandom();
                    c.target[i] = $urandom();
                    c.up[i] = $urandom();
                end
            end
            SHAPE_SAME_POINT: begin
                c.target = c.eye;
            end
            SHAPE_ZERO_UP: begin
                c.up = '{0, 0, 0};
            end
            SHAPE_EDGE: begin
                for (int i = 0; i < 3; i++) begin
                    c.eye[i] = $urandom_range(0, 1) ? DW'(WMAX) : DW'(WMIN);
                    if ($urandom_range(0, 1)) c.target[i] = -c.eye[i] - 1;
                end
            end
            default: begin
            end
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        $display("MISMATCH row %0d %s: got %h, want %h", rows_checked, what, got, want);
        mismatches++;
    endtask

    // Receiver readiness: a mode that changes every so often (always ready,
    // random stalls, or a regular pattern), plus a long hold-off on request.
    initial begin
        int mode;
        int mode_left;
        int phase;
        int hold_left;
        mode = 0;
        mode_left = 0;
        phase = 0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (mode == 0) begin
                m_ready <= 1'b1;
            end else if (mode == 1) begin
                m_ready <= $urandom_range(0, 3) != 0;
            end else begin
                m_ready <= (phase % 5) < 3;
            end
        end
    end

    // Checks each accepted row against the oldest one owed.
    always @(posedge aclk) begin
        row_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rows.size() == 0) begin
                $display("MISMATCH row %0d arrived with nothing owed", rows_checked);
                mismatches++;
            end else begin
                want = pending_rows.pop_front();
                if (m_row_index !== want.idx) report_mismatch("row_index", m_row_index, want.idx);
                if (m_col0 !== want.c0) report_mismatch("col0", m_col0, want.c0);
                if (m_col1 !== want.c1) report_mismatch("col1", m_col1, want.c1);
                if (m_col2 !== want.c2) report_mismatch("col2", m_col2, want.c2);
                if (m_col3 !== want.c3) report_mismatch("col3", m_col3, want.c3);
                if (m_last_row !== want.last) report_mismatch("last_row", m_last_row, want.last);
                if (m_degenerate !== want.degen) begin
                    report_mismatch("degenerate", m_degenerate, want.degen);
                end
            end
            rows_checked++;
        end
    end

    // Ends a hung run: counts cycles in which neither channel moves anything.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d cycles without a transaction", idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and the special cases: identical eye and target, a zero
    // up hint, both at once, up parallel to forward, saturating translations.
    task automatic test_directed();
        localparam longint ONE = 1 << FB;
        send_camera(make_camera(0, 0, ONE * 5, 0, 0, 0, 0, ONE, 0));
        send_camera(make_camera(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0));
        send_camera(make_camera(ONE, 0, 0, 0, 0, 0, 0, 0, 0));
        send_camera(make_camera(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_camera(make_camera(0, 0, 0, 0, ONE, 0, 0, 3 * ONE, 0));
        send_camera(make_camera(WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, WMAX, WMAX, WMAX));
        send_camera(make_camera(WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, WMIN, WMIN, WMIN));
        send_camera(make_camera(WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, 1));
        send_camera(make_camera(WMAX, WMIN, 0, 0, 0, 0, 1, 0, 0));
        send_camera(make_camera(-1, -1, -1, 0, 0, 0, -1, 0, 0));
        send_camera(make_camera(1, 0, 0, 0, 0, 0, 0, 0, -1));
        send_camera(make_camera(-1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_camera(make_camera(WMAX, 0, 0, WMAX - 1, 0, 0, 0, WMIN, 0));
        send_camera(make_camera(0, WMIN, 0, ONE, WMIN + 7, 3, 0, 0, WMAX));
        send_camera(make_camera(3 * ONE, ONE, -4 * ONE, 0, 0, 0, ONE, ONE, 0));
        send_camera(make_camera(WMAX, WMAX, WMAX, WMAX - ONE, WMAX, WMAX - ONE,
                                0, ONE, ONE));
        wait_for_drain();
    endtask

    task automatic test_random();
        int pick;
        shape_e shape;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 11) shape = SHAPE_SCENE;
            else if (pick < 15) shape = SHAPE_BITS;
            else if (pick < 17) shape = SHAPE_EDGE;
            else if (pick < 18) shape = SHAPE_SAME_POINT;
            else if (pick < 19) shape = SHAPE_ZERO_UP;
            else shape = SHAPE_SCENE;
            send_camera(random_camera(shape));
        end
    endtask

    // The receiver holds off for a long stretch while cameras keep coming,
    // more of them than the pipeline has stages, so the pipeline fills and
    // the input channel has to stall.
    task automatic test_backpressure();
        hold_request = HOLD_OFF_CYCLES;
        burst_left = 40;
        for (int n = 0; n < PRESSURE_ITEMS; n++) send_camera(random_camera(SHAPE_SCENE));
        wait_for_drain();
    endtask

    initial begin
        aresetn    <= 1'b0;
        s_valid    <= 1'b0;
        s_eye_x    <= '0;
        s_eye_y    <= '0;
        s_eye_z    <= '0;
        s_target_x <= '0;
        s_target_y <= '0;
        s_target_z <= '0;
        s_up_x     <= '0;
        s_up_y     <= '0;
        s_up_z     <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random();
        wait_for_drain();
        repeat (PIPE_LAT + 16) @(posedge aclk);

        $display("Covered %0d cameras and %0d rows, %0d of the cameras degenerate.",
                 matrices_sent, rows_checked, degenerate_sent);
        $display("Saturated elements %s seen; one long receiver hold-off and drained pauses.",
                 saturated_seen ? "were" : "were not");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/lav_pkg.sv
rtl/lav_norm.sv
rtl/lav_xform.sv
rtl/lav_rowser.sv
rtl/look_at_view_matrix.sv
test/tb_top.sv
